>>> hw/rtl/led_current_pi_regulator_core_assert.svh
// ----------------------------------------------------------------------------
// LED current regulator assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_CURRENT_PI_REGULATOR_CORE_ASSERT_SVH
`define LED_CURRENT_PI_REGULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define LCPR_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lcpr: invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define LCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcpr: sequence violated");

`else

`define LCPR_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define LCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/lcpr_pkg.sv
// ----------------------------------------------------------------------------
// LED current regulator package
// Field widths, register indexes, shared structs and the brightness table.
// ----------------------------------------------------------------------------
package lcpr_pkg;

    // Field widths of the request and result channels.
    localparam int ADC_W      = 10;
    localparam int BRIGHT_W   = 6;
    localparam int SHIFT_W    = 5;
    localparam int PSHIFT_W   = 4;
    localparam int DUTY_W     = 11;
    localparam int TARGET_W   = 16;
    localparam int INTEG_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Serial multiplier operand widths: the wide operand, the serial operand
    // and the full product.
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 10;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Request opcodes.
    localparam logic OP_TARGET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NIGHT_BRIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAY_BRIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HYS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SHIFT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_SHIFT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_SHIFT   = 3'd7;

    // Command from the sequencer to the serial multiplier.
    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } lcpr_mul_ctrl_t;

    // Status returned by the serial multiplier.
    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } lcpr_mul_stat_t;

    // Exponential brightness table; indexes from 32 up saturate to full scale.
    function automatic logic [TARGET_W-1:0] lcpr_exp_word(input logic [BRIGHT_W-1:0] idx);
        logic [TARGET_W-1:0] word;
        begin
            unique case (idx)
                6'd0:    word = 16'h0000;
                6'd1:    word = 16'h0001;
                6'd2:    word = 16'h0002;
                6'd3:    word = 16'h0003;
                6'd4:    word = 16'h0004;
                6'd5:    word = 16'h0006;
                6'd6:    word = 16'h0008;
                6'd7:    word = 16'h000b;
                6'd8:    word = 16'h0010;
                6'd9:    word = 16'h0017;
                6'd10:   word = 16'h0020;
                6'd11:   word = 16'h002d;
                6'd12:   word = 16'h0040;
                6'd13:   word = 16'h005b;
                6'd14:   word = 16'h0080;
                6'd15:   word = 16'h00b5;
                6'd16:   word = 16'h0100;
                6'd17:   word = 16'h016a;
                6'd18:   word = 16'h0200;
                6'd19:   word = 16'h02d4;
                6'd20:   word = 16'h0400;
                6'd21:   word = 16'h05a8;
                6'd22:   word = 16'h0800;
                6'd23:   word = 16'h0b50;
                6'd24:   word = 16'h1000;
                6'd25:   word = 16'h16a1;
                6'd26:   word = 16'h2000;
                6'd27:   word = 16'h2d41;
                6'd28:   word = 16'h4000;
                6'd29:   word = 16'h5a82;
                6'd30:   word = 16'h8000;
                6'd31:   word = 16'hb505;
                default: word = 16'hffff;
            endcase
            return word;
        end
    endfunction

endpackage

>>> hw/rtl/lcpr_if.sv
// ----------------------------------------------------------------------------
// LED current regulator channel interfaces
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------

// Request channel: one target update or control tick per request.
interface lcpr_item_if import lcpr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADC_W-1:0]  battery_sample;
    logic [ADC_W-1:0]  ambient_light;
    logic              button_held;
    logic              user_active;
    logic [ADC_W-1:0]  led_current;

    modport source
    (
        output valid, opcode, battery_sample, ambient_light, button_held,
               user_active, led_current,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, battery_sample, ambient_light, button_held,
               user_active, led_current,
        output ready
    );
endinterface

// Result channel: the regulator outputs after each request.
interface lcpr_result_if import lcpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   pwm_duty;
    logic [TARGET_W-1:0] current_target;
    logic                boost_on;
    logic                dark_off;

    modport source
    (
        output valid, pwm_duty, current_target, boost_on, dark_off,
        input  ready
    );

    modport sink
    (
        input  valid, pwm_duty, current_target, boost_on, dark_off,
        output ready
    );
endinterface

>>> hw/rtl/lcpr_serial_mul.sv
// ----------------------------------------------------------------------------
// LED current regulator serial multiplier
// Bit-serial shift-and-add multiplier: one bit of the serial operand per cycle.
// ----------------------------------------------------------------------------
module lcpr_serial_mul import lcpr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  lcpr_mul_ctrl_t ctrl,
    output lcpr_mul_stat_t stat
);

    logic [MUL_P_W-1:0]   acc_reg;
    logic [MUL_P_W-1:0]   acc_next;
    logic [MUL_P_W-1:0]   mcand_reg;
    logic [MUL_B_W-1:0]   mplier_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(MUL_B_W - 1);

    // Add the shifted multiplicand when the current multiplier bit is set.
    always_comb
    begin
        acc_next = acc_reg;
        if (mplier_reg[0])
        begin
            acc_next = acc_reg + mcand_reg;
        end
    end

    // Control: busy while stepping through the serial operand, one bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: accumulator, left-shifting multiplicand, right-shifting multiplier.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= MUL_P_W'(ctrl.a);
            mplier_reg <= ctrl.b;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_next;
            mcand_reg  <= {mcand_reg[MUL_P_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[MUL_B_W-1:1]};
        end
    end

    assign stat.done    = done_reg;
    assign stat.product = acc_reg;

endmodule

>>> hw/rtl/led_current_pi_regulator_core.sv
// ----------------------------------------------------------------------------
// LED current regulator core
// Sets an LED current target and runs a clamped PI loop on the PWM duty.
// Requests arrive on the item channel (valid/ready); opcode 0 is a target
// update, opcode 1 a control tick. Each request gives one result on the
// result channel holding duty, target, boost and dark flags after it.
// A control tick runs through the prepare state and the two tick states to
// the result; a target update runs two passes through the bit-serial
// multiplier (a load and ten add steps each), or goes straight to the
// result when the night light is latched dark.
// One request is processed at a time; the next can be accepted as soon
// as the previous result sits in the output register, even if not yet
// taken.
// If the receiver stalls with a result still pending, the finished request
// waits in its final state and no new request is accepted.
// Reset clears the state (boost on) and loads the register defaults.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must write them while the core is idle, the core does not enforce it.
// ----------------------------------------------------------------------------
`include "led_current_pi_regulator_core_assert.svh"

module led_current_pi_regulator_core import lcpr_pkg::*;
#(
    parameter int unsigned LIGHT_FACTOR_MAX = 240,
    parameter int unsigned LIGHT_FACTOR_MIN = 10,
    parameter int unsigned PWM_MAX          = 1024,
    parameter int unsigned PWM_MIN          = 0,
    parameter int          INTEGRAL_MAX     = 65535,
    parameter int          INTEGRAL_MIN     = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lcpr_item_if.sink             item,
    lcpr_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SUM_W = INTEG_W + 2;

    localparam logic [ADC_W-1:0]        LF_MAX  = ADC_W'(LIGHT_FACTOR_MAX);
    localparam logic [ADC_W-1:0]        LF_MIN  = ADC_W'(LIGHT_FACTOR_MIN);
    localparam logic signed [SUM_W-1:0] PMAX_S  = SUM_W'(PWM_MAX);
    localparam logic signed [SUM_W-1:0] PMIN_S  = SUM_W'(PWM_MIN);
    localparam logic signed [SUM_W-1:0] IMAX_S  = SUM_W'(INTEGRAL_MAX);
    localparam logic signed [SUM_W-1:0] IMIN_S  = SUM_W'(INTEGRAL_MIN);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_MUL2  = 3'd3;
    localparam logic [2:0] ST_TICK2 = 3'd4;
    localparam logic [2:0] ST_TICK3 = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Configuration registers.
    logic                night_mode_reg;
    logic [BRIGHT_W-1:0] night_bright_reg;
    logic [BRIGHT_W-1:0] day_bright_reg;
    logic [ADC_W-1:0]    light_thr_reg;
    logic [ADC_W-1:0]    light_hys_reg;
    logic [SHIFT_W-1:0]  target_shift_reg;
    logic [SHIFT_W-1:0]  integ_shift_reg;
    logic [PSHIFT_W-1:0] prop_shift_reg;

    // Regulator state.
    logic                      latch_reg;
    logic [TARGET_W-1:0]       target_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      boost_reg;

    // Sequencer and captured request.
    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic                op_reg;
    logic [ADC_W-1:0]    battery_reg;
    logic [ADC_W-1:0]    ambient_reg;
    logic                button_reg;
    logic                active_reg;
    logic [ADC_W-1:0]    led_reg;
    logic [ADC_W-1:0]    factor_reg;

    // Control tick pipeline registers.
    logic signed [ADC_W+6:0]   err_reg;
    logic signed [INTEG_W-1:0] iterm_reg;
    logic signed [INTEG_W-1:0] pterm_reg;

    // Output register.
    logic                out_valid_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic [TARGET_W-1:0] out_target_reg;
    logic                out_boost_reg;
    logic                out_dark_reg;

    // Combinational helpers.
    logic                      accept;
    logic                      load_out;
    logic                      latch_new;
    logic signed [ADC_W+1:0]   amb_s;
    logic signed [ADC_W+1:0]   thr_s;
    logic signed [ADC_W+1:0]   band_lo;
    logic signed [ADC_W+1:0]   band_hi;
    logic [ADC_W-1:0]          factor_sel;
    logic [BRIGHT_W-1:0]       bright_sel;
    logic signed [ADC_W+6:0]   err_now;
    logic signed [SUM_W-1:0]   integ_sum;
    logic signed [SUM_W-1:0]   integ_clamped;
    logic signed [SUM_W-1:0]   pwm_sum;
    logic signed [SUM_W-1:0]   pwm_clamped;
    logic [MUL_P_W-1:0]        scaled;
    logic [TARGET_W-1:0]       target_sat;
    lcpr_mul_ctrl_t            mul_ctrl;
    lcpr_mul_stat_t            mul_stat;

    assign accept   = item.valid && item.ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // Night light hysteresis latch, compared as signed values.
    always_comb
    begin
        amb_s   = signed'({2'b00, ambient_reg});
        thr_s   = signed'({2'b00, light_thr_reg});
        band_lo = thr_s - signed'({2'b00, light_hys_reg});
        band_hi = thr_s + signed'({2'b00, light_hys_reg});
        if (button_reg)
        begin
            latch_new = amb_s > thr_s;
        end
        else if (active_reg)
        begin
            latch_new = 1'b0;
        end
        else if (latch_reg && (amb_s < band_lo))
        begin
            latch_new = 1'b0;
        end
        else if (!latch_reg && (amb_s > band_hi))
        begin
            latch_new = 1'b1;
        end
        else
        begin
            latch_new = latch_reg;
        end
    end

    // Light factor and brightness index for the target product.
    always_comb
    begin
        if (night_mode_reg)
        begin
            factor_sel = LF_MAX;
            bright_sel = night_bright_reg;
        end
        else
        begin
            bright_sel = day_bright_reg;
            if (ambient_reg > LF_MAX)
            begin
                factor_sel = LF_MAX;
            end
            else if (ambient_reg < LF_MIN)
            begin
                factor_sel = LF_MIN;
            end
            else
            begin
                factor_sel = ambient_reg;
            end
        end
    end

    // Integrator update: subtract the error and clamp the full sum.
    always_comb
    begin
        err_now   = signed'({7'b0, led_reg}) - signed'({1'b0, target_reg});
        integ_sum = SUM_W'(integ_reg) - SUM_W'(err_now);
        integ_clamped = integ_sum;
        if (integ_clamped < IMIN_S)
        begin
            integ_clamped = IMIN_S;
        end
        if (integ_clamped > IMAX_S)
        begin
            integ_clamped = IMAX_S;
        end
    end

    // Duty from the integral term minus the proportional term, clamped to the PWM range.
    always_comb
    begin
        pwm_sum     = SUM_W'(iterm_reg) - SUM_W'(pterm_reg);
        pwm_clamped = pwm_sum;
        if (pwm_clamped > PMAX_S)
        begin
            pwm_clamped = PMAX_S;
        end
        if (pwm_clamped < PMIN_S)
        begin
            pwm_clamped = PMIN_S;
        end
    end

    // Target scaling and saturation of the final product.
    always_comb
    begin
        scaled     = mul_stat.product >> target_shift_reg;
        target_sat = (|scaled[MUL_P_W-1:TARGET_W]) ? {TARGET_W{1'b1}} : scaled[TARGET_W-1:0];
    end

    // Multiplier commands: table word times battery, then times light factor.
    always_comb
    begin
        mul_ctrl.start = 1'b0;
        mul_ctrl.a     = MUL_A_W'(lcpr_exp_word(bright_sel));
        mul_ctrl.b     = battery_reg;
        if ((state_reg == ST_PREP) && (op_reg == OP_TARGET) &&
            !(night_mode_reg && latch_new))
        begin
            mul_ctrl.start = 1'b1;
        end
        else if ((state_reg == ST_MUL1) && mul_stat.done)
        begin
            mul_ctrl.start = 1'b1;
            mul_ctrl.a     = mul_stat.product[MUL_A_W-1:0];
            mul_ctrl.b     = factor_reg;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (op_reg == OP_TICK)
                begin
                    state_next = ST_TICK2;
                end
                else if (night_mode_reg && latch_new)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK2:
            begin
                state_next = ST_TICK3;
            end
            ST_TICK3:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item.ready = (state_reg == ST_IDLE);

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_mode_reg   <= 1'b0;
            night_bright_reg <= '0;
            day_bright_reg   <= '0;
            light_thr_reg    <= '0;
            light_hys_reg    <= '0;
            target_shift_reg <= SHIFT_W'(16);
            integ_shift_reg  <= SHIFT_W'(4);
            prop_shift_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NIGHT_MODE:   night_mode_reg   <= cfg_data[0];
                REG_NIGHT_BRIGHT: night_bright_reg <= cfg_data[BRIGHT_W-1:0];
                REG_DAY_BRIGHT:   day_bright_reg   <= cfg_data[BRIGHT_W-1:0];
                REG_LIGHT_THR:    light_thr_reg    <= cfg_data[ADC_W-1:0];
                REG_LIGHT_HYS:    light_hys_reg    <= cfg_data[ADC_W-1:0];
                REG_TARGET_SHIFT: target_shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_INTEG_SHIFT:  integ_shift_reg  <= cfg_data[SHIFT_W-1:0];
                REG_PROP_SHIFT:   prop_shift_reg   <= cfg_data[PSHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture of the accepted request and intermediate terms.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= item.opcode;
            battery_reg <= item.battery_sample;
            ambient_reg <= item.ambient_light;
            button_reg  <= item.button_held;
            active_reg  <= item.user_active;
            led_reg     <= item.led_current;
        end
        if (state_reg == ST_PREP)
        begin
            factor_reg <= factor_sel;
            err_reg    <= err_now;
        end
        if (state_reg == ST_TICK2)
        begin
            iterm_reg <= integ_reg >>> integ_shift_reg;
            pterm_reg <= INTEG_W'(err_reg) <<< prop_shift_reg;
        end
    end

    // Regulator state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= 1'b0;
            target_reg <= '0;
            integ_reg  <= '0;
            duty_reg   <= '0;
            boost_reg  <= 1'b1;
        end
        else
        begin
            if (state_reg == ST_PREP)
            begin
                if (op_reg == OP_TICK)
                begin
                    integ_reg <= integ_clamped[INTEG_W-1:0];
                end
                else
                begin
                    latch_reg <= night_mode_reg && latch_new;
                    if (night_mode_reg && latch_new)
                    begin
                        target_reg <= '0;
                    end
                end
            end
            if ((state_reg == ST_MUL2) && mul_stat.done)
            begin
                target_reg <= target_sat;
                boost_reg  <= !night_mode_reg;
            end
            if (state_reg == ST_TICK3)
            begin
                duty_reg <= pwm_clamped[DUTY_W-1:0];
            end
        end
    end

    // Output register: holds the result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_duty_reg   <= duty_reg;
            out_target_reg <= target_reg;
            out_boost_reg  <= boost_reg;
            out_dark_reg   <= latch_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.pwm_duty       = out_duty_reg;
    assign result.current_target = out_target_reg;
    assign result.boost_on       = out_boost_reg;
    assign result.dark_off       = out_dark_reg;

    lcpr_serial_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mul_ctrl),
        .stat  (mul_stat)
    );

    // The night light is only latched dark together with a zero target.
    `LCPR_ASSERT_ALWAYS(a_dark_zero_target, clk, rst_n, !latch_reg || (target_reg == '0))
    // The integrator never leaves its clamp range.
    `LCPR_ASSERT_ALWAYS(a_integ_range, clk, rst_n,
        (SUM_W'(integ_reg) >= IMIN_S) && (SUM_W'(integ_reg) <= IMAX_S))
    // The duty never exceeds the PWM ceiling when that ceiling fits the field.
    `LCPR_ASSERT_ALWAYS(a_duty_max, clk, rst_n,
        (PWM_MAX > 2047) || (32'(duty_reg) <= PWM_MAX))
    // An accepted request always starts the sequencer.
    `LCPR_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg == ST_PREP)

endmodule
